// ===== rtl/bia_pkg.sv =====
// Shared types and constants for the bitmap identifier allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package bia_pkg;

  // Bits per bitmap word and index widths fixed by the field layout
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int TOP_W     = 10;
  localparam int ID_W      = 16;

  // Request codes
  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLAIM = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic CFG_BASE_ID    = 1'b0;
  localparam logic CFG_TOP_OFFSET = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, issue first word read
    logic step;     // move scan to the next word
    logic finish;   // update bitmap and latch result
  } bia_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;       // current scan word has a free in-range bit
    logic scan_end;  // current scan word is the last one to check
  } bia_stat_t;

endpackage

`default_nettype wire

// ===== rtl/bia_ctrl.sv =====
// Sequencing state machine for the bitmap identifier allocator.
// Depends on bia_pkg for the command, status and request types.
`default_nettype none

module bia_ctrl
  import bia_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire action_t   action,
  output logic           out_valid,
  input  wire logic      out_stall,
  output bia_cmd_t       cmd,
  input  wire bia_stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take a new beat when idle, or when the held result leaves this cycle
  assign in_stall  = !((state == ST_IDLE) || ((state == ST_DONE) && !out_stall));
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state == ST_DONE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.capture = accept;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (action == ACT_ALLOC) ? ST_SCAN : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.finish = 1'b1;
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        // stop on a hit or after the last word in range
        if (stat.hit || stat.scan_end) begin
          cmd.finish = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (accept) begin
          state_next = (action == ACT_ALLOC) ? ST_SCAN : ST_LOOKUP;
        end else if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bia_dpath.sv =====
// Datapath of the bitmap identifier allocator: config registers, bitmap
// memory with per-word valid flags, scan pointer and result registers.
// Depends on bia_pkg for the command, status and request types.
`default_nettype none

module bia_dpath
  import bia_pkg::*;
#(
  parameter int MAX_IDS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bia_cmd_t          cmd,
  output bia_stat_t              stat,
  input  wire action_t           action,
  input  wire logic [ID_W-1:0]   id_value,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [ID_W-1:0]   cfg_data,
  output logic [ID_W-1:0]        result_id,
  output logic                   success
);

  // Only words holding bit indexes up to the widest top_offset are ever used
  localparam int NUM_WORDS = MAX_IDS / WORD_BITS;
  localparam int DEPTH     = (NUM_WORDS > 32) ? 32 : NUM_WORDS;
  localparam int WW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TOP_CAP   = (MAX_IDS - 1 > 1023) ? 1023 : MAX_IDS - 1;

  // Configuration and control state
  logic [ID_W-1:0]  base_id;
  logic [TOP_W-1:0] top_offset;
  logic [WW-1:0]    last_word;

  // Per-request state
  action_t          op;
  logic [ID_W-1:0]  op_id;
  logic [BIT_W-1:0] op_bit;
  logic             op_in_range;
  logic [WW-1:0]    chk_word;
  logic [WW-1:0]    ptr;
  logic [WW-1:0]    cnt;

  // Bitmap storage
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     word_valid;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_v;
  logic [WW-1:0]        rd_addr;
  logic                 rd_en;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;

  // Combinational helpers
  logic [TOP_W-1:0]     top_a;
  logic [ID_W-1:0]      room;
  logic [TOP_W-1:0]     top;
  logic [WW-1:0]        top_word;
  logic [WW-1:0]        start_word;
  logic [ID_W-1:0]      diff;
  logic                 id_in_range;
  logic [WW-1:0]        id_word;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] range_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     free_j;
  logic [WORD_BITS-1:0] op_mask;
  logic [ID_W-1:0]      res_id_next;
  logic                 success_next;

  // Clip the top index to the storage and to the 16-bit id space
  always_comb begin
    top_a    = (top_offset > TOP_W'(TOP_CAP)) ? TOP_W'(TOP_CAP) : top_offset;
    room     = {ID_W{1'b1}} - base_id;
    top      = (room < {{(ID_W-TOP_W){1'b0}}, top_a}) ? room[TOP_W-1:0] : top_a;
    top_word = WW'(top[TOP_W-1:BIT_W]);
    start_word = (last_word <= top_word) ? last_word : '0;
  end

  // Range check of the request id
  always_comb begin
    diff        = id_value - base_id;
    id_in_range = (id_value >= base_id) && (diff <= {{(ID_W-TOP_W){1'b0}}, top});
    id_word     = id_in_range ? WW'(diff[TOP_W-1:BIT_W]) : '0;
  end

  // Read address: start of scan or request word on capture, next word on step
  always_comb begin
    rd_en   = cmd.capture || cmd.step;
    rd_addr = ptr;
    if (cmd.capture) begin
      rd_addr = (action == ACT_ALLOC) ? start_word : id_word;
    end
  end

  // Word under test; a never-written word reads as all clear
  assign word = rd_v ? rd_q : '0;

  // Find the lowest clear bit in range of the current word
  always_comb begin
    range_mask = {WORD_BITS{1'b1}};
    if (chk_word == top_word) begin
      range_mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - top[BIT_W-1:0]);
    end
    free_bits = ~word & range_mask;
    free_j    = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_j = BIT_W'(i);
      end
    end
  end

  assign stat.hit      = |free_bits;
  assign stat.scan_end = (cnt == top_word);

  // Bitmap update and result for the request in progress
  always_comb begin
    op_mask      = WORD_BITS'(1) << op_bit;
    wr_en        = 1'b0;
    wr_data      = word;
    res_id_next  = '0;
    success_next = 1'b0;
    case (op)
      ACT_ALLOC: begin
        if (stat.hit) begin
          wr_en        = 1'b1;
          wr_data      = word | (WORD_BITS'(1) << free_j);
          res_id_next  = base_id + ID_W'({chk_word, free_j});
          success_next = 1'b1;
        end
      end
      ACT_FREE: begin
        if (op_in_range) begin
          wr_en        = 1'b1;
          wr_data      = word & ~op_mask;
          success_next = 1'b1;
        end
      end
      ACT_CLAIM: begin
        if (op_in_range && !word[op_bit]) begin
          wr_en        = 1'b1;
          wr_data      = word | op_mask;
          res_id_next  = op_id;
          success_next = 1'b1;
        end
      end
      ACT_QUERY: begin
        success_next = op_in_range && word[op_bit];
      end
      default: begin
        success_next = 1'b0;
      end
    endcase
    wr_en = wr_en && cmd.finish;
  end

  // Bitmap memory with registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[chk_word] <= wr_data;
    end
  end

  // Word valid flags and registered read flag
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_v       <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_v <= word_valid[rd_addr];
      end
      if (wr_en) begin
        word_valid[chk_word] <= 1'b1;
      end
    end
  end

  // Configuration registers and next-fit pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      base_id    <= ID_W'(1);
      top_offset <= {TOP_W{1'b1}};
      last_word  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_ID:    base_id    <= cfg_data;
          CFG_TOP_OFFSET: top_offset <= cfg_data[TOP_W-1:0];
          default:        base_id    <= base_id;
        endcase
      end
      if (cmd.finish && (op == ACT_ALLOC) && stat.hit) begin
        last_word <= chk_word;
      end
    end
  end

  // Request latch and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op          <= action;
      op_id       <= id_value;
      op_bit      <= diff[BIT_W-1:0];
      op_in_range <= id_in_range;
      cnt         <= '0;
      if (action == ACT_ALLOC) begin
        chk_word <= start_word;
        ptr      <= (start_word == top_word) ? '0 : start_word + WW'(1);
      end else begin
        chk_word <= id_word;
        ptr      <= id_word;
      end
    end else if (cmd.step) begin
      chk_word <= ptr;
      ptr      <= (ptr == top_word) ? '0 : ptr + WW'(1);
      cnt      <= cnt + WW'(1);
    end
  end

  // Hold the result until the next request finishes
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_id <= res_id_next;
      success   <= success_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bitmap_id_allocator.sv =====
// Next-fit bitmap identifier allocator. Free, claim and query: one word read,
// then bitmap update and registered result. Allocate: examines 1 to 32 words, one
// bitmap word per cycle through the single registered memory read port.
// A new beat is accepted in the cycle the held result is taken.
// Reset (rst, synchronous): bitmap reads as all clear via per-word valid
// flags, base_id 1, top_offset 1023, scan start word 0; no clearing pass.
`default_nettype none

module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int MAX_IDS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       action,
  input  wire logic [ID_W-1:0]  id_value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [ID_W-1:0]       result_id,
  output logic                  success,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [ID_W-1:0]  cfg_data
);

  bia_cmd_t  cmd;
  bia_stat_t stat;
  action_t   act;

  assign act       = action_t'(action);
  assign cfg_ready = 1'b1;

  // Sequencer
  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (act),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Bitmap, registers and result
  bia_dpath #(
    .MAX_IDS (MAX_IDS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .action    (act),
    .id_value  (id_value),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result_id (result_id),
    .success   (success)
  );

endmodule

`default_nettype wire

// ===== rtl/bia_checker.sv =====
// Port-level checks for the bitmap identifier allocator, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module bia_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] result_id,
  input wire logic        success
);

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A nonzero id is only returned on success
  a_id_success: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_id != 16'd0) |-> success)
    else $error("nonzero id without success");

  // An accepted beat goes through a lookup or scan state before its result
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result shown right after accept");

  // No new beat while a result waits
  a_one_outstanding: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .result_id (result_id),
  .success   (success)
);

`default_nettype wire

// ===== tb/tb_bitmap_id_allocator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_id_allocator: directed and random
// allocate/free/claim/query traffic across several range settings, checked
// against an in-bench next-fit bitmap predictor. Depends on rtl/bia_pkg.sv.

module tb_bitmap_id_allocator;
  import bia_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int MAX_IDS        = 1024;
  localparam int NUM_WORDS      = MAX_IDS / WORD_BITS;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int NUM_PHASES     = 8;
  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

  typedef struct {
    action_t         act;
    logic [ID_W-1:0] id;
  } request_t;

  typedef struct {
    logic [ID_W-1:0] rid;
    logic            ok;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  action_t           action = ACT_ALLOC;
  logic [ID_W-1:0]   id_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ID_W-1:0]   result_id;
  logic              success;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_BASE_ID;
  logic [ID_W-1:0]   cfg_data = '0;

  // Predictor state: bitmap, next-fit start word and the two registers
  logic [WORD_BITS-1:0] used_map [NUM_WORDS];
  int                   scan_word = 0;
  logic [ID_W-1:0]      range_base = 16'd1;
  logic [TOP_W-1:0]     range_top_offset = 10'd1023;

  request_t request_queue[$];
  reply_t   awaited_replies[$];
  int       error_count = 0;
  int       idle_cycles = 0;

  bitmap_id_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .id_value  (id_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result_id (result_id),
    .success   (success),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Highest usable bit index after clipping to the bitmap and to 16-bit ids
  function automatic int range_top();
    int t;
    t = int'(range_top_offset);
    if (t > MAX_IDS - 1) t = MAX_IDS - 1;
    if (t > 65535 - int'(range_base)) t = 65535 - int'(range_base);
    return t;
  endfunction

  // Apply one accepted request to the bitmap and queue the reply it yields
  function automatic void apply_request(input action_t act, input logic [ID_W-1:0] id);
    reply_t r;
    int     top, nw, w, n, j, idx;
    bit     in_range;
    top = range_top();
    r.rid = '0;
    r.ok = 1'b0;
    in_range = (int'(id) >= int'(range_base)) && (int'(id) - int'(range_base) <= top);
    idx = int'(id) - int'(range_base);
    case (act)
      ACT_ALLOC: begin
        nw = top / WORD_BITS + 1;
        w = (scan_word < nw) ? scan_word : 0;
        for (n = 0; n < nw && !r.ok; n++) begin
          if (used_map[w] != FULL_WORD) begin
            for (j = 0; j < WORD_BITS && !r.ok && w * WORD_BITS + j <= top; j++) begin
              if (!used_map[w][j]) begin
                used_map[w][j] = 1'b1;
                scan_word = w;
                r.rid = range_base + ID_W'(w * WORD_BITS + j);
                r.ok = 1'b1;
              end
            end
          end
          w = (w + 1 == nw) ? 0 : w + 1;
        end
      end
      ACT_FREE: begin
        if (in_range) begin
          used_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
          r.ok = 1'b1;
        end
      end
      ACT_CLAIM: begin
        if (in_range && !used_map[idx / WORD_BITS][idx % WORD_BITS]) begin
          used_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
          r.rid = id;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (in_range && used_map[idx / WORD_BITS][idx % WORD_BITS]) r.ok = 1'b1;
      end
    endcase
    awaited_replies.push_back(r);
  endfunction

  // Sender: present queued requests in bursts separated by random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    request_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_request(action, id_value);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          req = request_queue.pop_front();
          in_valid <= 1'b1;
          action <= req.act;
          id_value <= req.id;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall with a duty cycle of 0, 25, 50 or 90 percent, redrawn at random
  int stall_pct = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        $error("result beat with nothing outstanding: result_id %0d success %0b",
               result_id, success);
        error_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (result_id !== want.rid) begin
          $error("result_id mismatch: expected %0d, actual %0d", want.rid, result_id);
          error_count++;
        end
        if (success !== want.ok) begin
          $error("success mismatch: expected %0b, actual %0b", want.ok, success);
          error_count++;
        end
      end
    end
    if (stall_left == 0) begin
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 50;
        default: stall_pct = 90;
      endcase
      stall_left = $urandom_range(50, 300);
    end
    stall_left--;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_req(input action_t act, input logic [ID_W-1:0] id);
    request_t req;
    req.act = act;
    req.id = id;
    request_queue.push_back(req);
  endtask

  // Block until every request is sent and every reply has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_valid || awaited_replies.size() != 0);
  endtask

  // Write one register and mirror it into the predictor on the handshake
  task automatic write_reg(input logic idx, input logic [ID_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BASE_ID) range_base = value;
    else range_top_offset = value[TOP_W-1:0];
  endtask

  // Random mix: allocations, plus free/claim/query mostly inside the range
  task automatic queue_random(input int count, input int alloc_pct);
    int              top, roll;
    logic [ID_W-1:0] id;
    action_t         act;
    top = range_top();
    repeat (count) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        act = ACT_ALLOC;
        id = ID_W'($urandom);
      end else begin
        act = action_t'($urandom_range(1, 3));
        roll = $urandom_range(0, 9);
        if (roll < 5) id = range_base + ID_W'($urandom_range(0, (top < 63) ? top : 63));
        else if (roll < 8) id = range_base + ID_W'($urandom_range(0, top));
        else if (roll == 8) id = $urandom_range(0, 1) ? range_base - ID_W'(1) :
                                                        range_base + ID_W'(top + 1);
        else id = ID_W'($urandom);
      end
      push_req(act, id);
    end
  endtask

  initial begin
    int phase_base [NUM_PHASES];
    int phase_top  [NUM_PHASES];
    int phase_alloc[NUM_PHASES];
    phase_base  = '{1, 1, 0, 65500, 65535, 300, 1000, 1};
    phase_top   = '{1023, 60, 20, 1023, 0, 0, 1023, 1023};
    phase_alloc = '{40, 70, 50, 50, 40, 40, 40, 35};
    foreach (used_map[i]) used_map[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset range 1..1024, edges of the range and every operation
    push_req(ACT_ALLOC, 16'h0000);
    push_req(ACT_ALLOC, 16'hFFFF);
    push_req(ACT_QUERY, 16'd1);
    push_req(ACT_QUERY, 16'd3);
    push_req(ACT_CLAIM, 16'd1);
    push_req(ACT_CLAIM, 16'd1024);
    push_req(ACT_QUERY, 16'd1024);
    push_req(ACT_CLAIM, 16'd1025);
    push_req(ACT_CLAIM, 16'd0);
    push_req(ACT_FREE, 16'd0);
    push_req(ACT_FREE, 16'd1025);
    push_req(ACT_FREE, 16'd1);
    push_req(ACT_QUERY, 16'd1);
    push_req(ACT_ALLOC, 16'h5555);
    push_req(ACT_QUERY, 16'hFFFF);
    push_req(ACT_FREE, 16'd1024);
    push_req(ACT_QUERY, 16'd1024);
    push_req(ACT_CLAIM, 16'd32);
    push_req(ACT_CLAIM, 16'd33);
    push_req(ACT_QUERY, 16'hAAAA);
    push_req(ACT_FREE, 16'h5555);
    push_req(ACT_ALLOC, 16'hAAAA);

    // Random phases; bitmap and scan word carry over across register writes
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_reg(CFG_BASE_ID, ID_W'(phase_base[p]));
        write_reg(CFG_TOP_OFFSET, ID_W'(phase_top[p]));
      end
      queue_random(85, phase_alloc[p]);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
